>>> hdl/lpi_pkg.sv
`default_nettype none

package lpi_pkg;

  localparam int LPI_COORD_BITS = 6;

  // per-axis stepper control
  typedef struct packed {
    logic load;
    logic init;
    logic step;
  } lpi_ax_ctl_t;

endpackage : lpi_pkg

`default_nettype wire

>>> hdl/lpi_axis.sv
`default_nettype none

module lpi_axis #(
  parameter int COORD_BITS = 6
) (
  input  wire                      clk,
  input  lpi_pkg::lpi_ax_ctl_t     ctl,
  input  wire  [COORD_BITS-1:0]    start_c,
  input  wire  [COORD_BITS-1:0]    tgt_c,
  input  wire  [COORD_BITS-1:0]    span,
  output logic [COORD_BITS-1:0]    dlt,
  output logic [COORD_BITS-1:0]    coord
);
  import lpi_pkg::*;

  logic [COORD_BITS-1:0] q_r, q_nxt;
  logic [COORD_BITS-1:0] r_r, r_nxt;
  logic [COORD_BITS-1:0] dlt_r, dlt_nxt;
  logic [COORD_BITS-1:0] dist_r, dist_nxt;
  logic                  neg_r, neg_nxt;
  logic [COORD_BITS:0]   sum;

  // remainder walk: numerator moves by the axis delta each point
  always_comb begin
    q_nxt    = q_r;
    r_nxt    = r_r;
    dlt_nxt  = dlt_r;
    dist_nxt = dist_r;
    neg_nxt  = neg_r;
    sum      = {1'b0, r_r} + {1'b0, dlt_r};
    if (ctl.load) begin
      q_nxt   = start_c;
      neg_nxt = (tgt_c < start_c);
      dlt_nxt = (tgt_c < start_c) ? (start_c - tgt_c) : (tgt_c - start_c);
    end else if (ctl.init) begin
      dist_nxt = span;
      r_nxt    = span >> 1;
    end else if (ctl.step) begin
      if (neg_r) begin
        if (r_r >= dlt_r) begin
          r_nxt = r_r - dlt_r;
        end else begin
          r_nxt = r_r + (dist_r - dlt_r);
          q_nxt = q_r - 1'b1;
        end
      end else begin
        if (sum >= {1'b0, dist_r}) begin
          r_nxt = COORD_BITS'(sum - {1'b0, dist_r});
          q_nxt = q_r + 1'b1;
        end else begin
          r_nxt = sum[COORD_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r    <= q_nxt;
    r_r    <= r_nxt;
    dlt_r  <= dlt_nxt;
    dist_r <= dist_nxt;
    neg_r  <= neg_nxt;
  end

  assign dlt   = dlt_r;
  assign coord = q_r;

endmodule : lpi_axis

`default_nettype wire

>>> hdl/line_point_interpolator.sv
// line_point_interpolator
// Walks a straight line between two points on a grid and hands out every
// point along it, rounded to the nearest grid position, one item each.
// Input channel (in_valid / in_stall): start and end coordinates. The block
// stalls its input from the cycle after an item is taken until the last
// point of that line has been loaded into the output register.
// Output channel (out_valid / out_stall): point_x, point_y and last_point,
// which marks the final point. A line of dist + 1 points, dist being the
// larger axis difference, yields exactly that many items; equal points
// yield one item, the start, marked last.
// Sequence: acceptance loads the per-axis remainder steppers, the INIT
// state sets their span, then the RUN state hands out one point per
// cycle while the receiver does not stall. The first point passes the
// INIT and RUN states before it reaches the output register. A stall simply
// freezes the walk; the output register holds its item and nothing is lost.
// Reset (rst_n low at a clock edge) empties the output register and
// returns the sequencer to idle; a line in progress is dropped.
`default_nettype none

module line_point_interpolator #(
  parameter int COORD_BITS = lpi_pkg::LPI_COORD_BITS
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire  [COORD_BITS-1:0]  in_start_x,
  input  wire  [COORD_BITS-1:0]  in_start_y,
  input  wire  [COORD_BITS-1:0]  in_end_x,
  input  wire  [COORD_BITS-1:0]  in_end_y,
  output logic                   out_valid,
  input  wire                    out_stall,
  output logic [COORD_BITS-1:0]  out_point_x,
  output logic [COORD_BITS-1:0]  out_point_y,
  output logic                   out_last_point
);
  import lpi_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_INIT = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  logic [1:0]            st_r, st_nxt;
  logic [COORD_BITS-1:0] dist_r, dist_nxt;
  logic [COORD_BITS-1:0] t_r, t_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [COORD_BITS-1:0] px_r, py_r;
  logic                  plast_r;

  logic [COORD_BITS-1:0] dlt_x, dlt_y, q_x, q_y;
  logic                  acc, emit, at_end;
  lpi_ax_ctl_t           ctl;

  assign in_stall = (st_r != ST_IDLE);
  assign acc      = in_valid && !in_stall;
  assign emit     = (st_r == ST_RUN) && (!out_valid_r || !out_stall);
  assign at_end   = (t_r == dist_r);

  assign ctl.load = acc;
  assign ctl.init = (st_r == ST_INIT);
  assign ctl.step = emit && !at_end;

  lpi_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
    .clk     (clk),
    .ctl     (ctl),
    .start_c (in_start_x),
    .tgt_c   (in_end_x),
    .span    (dist_nxt),
    .dlt     (dlt_x),
    .coord   (q_x)
  );

  lpi_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
    .clk     (clk),
    .ctl     (ctl),
    .start_c (in_start_y),
    .tgt_c   (in_end_y),
    .span    (dist_nxt),
    .dlt     (dlt_y),
    .coord   (q_y)
  );

  always_comb begin
    st_nxt        = st_r;
    dist_nxt      = dist_r;
    t_nxt         = t_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (st_r)
      ST_IDLE: begin
        if (acc) begin
          st_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        dist_nxt = (dlt_x > dlt_y) ? dlt_x : dlt_y;
        t_nxt    = '0;
        st_nxt   = ST_RUN;
      end
      ST_RUN: begin
        if (emit) begin
          out_valid_nxt = 1'b1;
          t_nxt         = t_r + 1'b1;
          if (at_end) begin
            st_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
    t_r    <= t_nxt;
    if (emit) begin
      px_r    <= q_x;
      py_r    <= q_y;
      plast_r <= at_end;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_point_x    = px_r;
  assign out_point_y    = py_r;
  assign out_last_point = plast_r;

endmodule : line_point_interpolator

`default_nettype wire

>>> hdl/lpi_checker.sv
`default_nettype none

module lpi_checker #(
  parameter int COORD_BITS = lpi_pkg::LPI_COORD_BITS
) (
  input wire                   clk,
  input wire                   rst_n,
  input wire                   in_valid,
  input wire                   in_stall,
  input wire                   out_valid,
  input wire                   out_stall,
  input wire  [COORD_BITS-1:0] out_point_x,
  input wire  [COORD_BITS-1:0] out_point_y,
  input wire                   out_last_point
);
  import lpi_pkg::*;

  // a held item does not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_point_x)
      && $stable(out_point_y) && $stable(out_last_point))
    else $error("output item changed while stalled");

  // busy once an item is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after an item was taken");

  // mid-line points only while the block is busy
  a_midline_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_point |-> in_stall)
    else $error("input free while a line is unfinished");

  // nothing follows the final point while no new line is set up
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_point && !in_stall |=> !out_valid)
    else $error("item appeared straight after the last point");

endmodule : lpi_checker

bind line_point_interpolator lpi_checker #(.COORD_BITS(COORD_BITS)) u_lpi_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_point_x    (out_point_x),
  .out_point_y    (out_point_y),
  .out_last_point (out_last_point)
);

`default_nettype wire
